FILE: hw/rtl/sine_voice_with_envelope_core_defines.svh
// ----------------------------------------------------------------------------
// sine voice assertion macros
// clocked checks on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef SINE_VOICE_WITH_ENVELOPE_CORE_DEFINES_SVH
`define SINE_VOICE_WITH_ENVELOPE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every edge
`define SVE_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("%m: check failed");

// same-cycle implication
`define SVE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define SVE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define SVE_ASSERT_ALWAYS(lbl, expr)
`define SVE_ASSERT_IMPLY(lbl, ante, cons)
`define SVE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/sve_pkg.sv
// ----------------------------------------------------------------------------
// sve_pkg
// shared constants, types and tables of the sine voice
// ----------------------------------------------------------------------------
`default_nettype none

package sve_pkg;

    // sizing
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 32;
    localparam int SAMPLE_BITS      = 16;
    localparam int ROM_ADDR_W       = $clog2(SINE_TABLE_DEPTH);

    // port fields
    localparam int CMD_W  = 2;
    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;
    localparam int RATE_W = 18;
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

    // q1.15 envelopes
    localparam int ENV_W    = 16;
    localparam int ENV_FRAC = 15;
    localparam logic [ENV_W-1:0] ENV_ONE   = 16'd32768;
    localparam logic [ENV_W-1:0] ENV_FLOOR = 16'd163;
    localparam int DECAY_FRAC = 16;
    localparam logic [ENV_W-1:0] DECAY_Q16   = 16'd64881;
    localparam logic [ENV_W-1:0] DECAY_ROUND = 16'd32768;

    // note frequency, octave 0 in q4.24
    localparam int FREQ_W        = 28;
    localparam int FREQ_FRAC     = 24;
    localparam int OCT_W         = 4;
    localparam int OCT_MAX       = 10;
    localparam int SEMI_W        = 4;
    localparam int NOTES_PER_OCT = 12;
    localparam int DIV12_MUL     = 43;
    localparam int DIV12_SHIFT   = 9;
    localparam int DIV12_W       = NOTE_W + 6;
    localparam int WIDE_W        = FREQ_W + PHASE_BITS + OCT_MAX;
    localparam int NUM_W         = WIDE_W - FREQ_FRAC;

    // serial divider
    localparam int DIV_W = RATE_W + PHASE_BITS;
    localparam int CNT_W = $clog2(PHASE_BITS + 1);

    // output scaling: |sine| * level * env / (127 * 32768)
    localparam int MAG_W       = SAMPLE_BITS - 1;
    localparam int P1_W        = MAG_W + VEL_W;
    localparam int P2_W        = P1_W + ENV_W;
    localparam int Y_W         = P2_W + 1 - ENV_FRAC;
    localparam int LEVEL_SHIFT = Y_W + VEL_W;
    localparam int RECIP_W     = LEVEL_SHIFT - VEL_W + 1;
    localparam int SCALE_W     = Y_W + RECIP_W;
    localparam longint unsigned LEVEL_MAX   = (longint'(1) << VEL_W) - 1;
    localparam longint unsigned LEVEL_DIV   = LEVEL_MAX << ENV_FRAC;
    localparam longint unsigned LEVEL_HALF  = LEVEL_DIV / 2;
    localparam longint unsigned LEVEL_RECIP =
        ((longint'(1) << LEVEL_SHIFT) + LEVEL_MAX - 1) / LEVEL_MAX;

    // sine table build
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] SAMPLE_FULL = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef enum logic [CMD_W-1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_LEVEL,
        S_MUL_ENV,
        S_SCALE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic tick;
        logic note_on;
        logic note_off;
        logic div_step;
        logic div_last;
        logic mul_level;
        logic mul_env;
        logic scale;
        logic load_out;
    } t_dp_cmd;

    typedef logic signed [SAMPLE_BITS-1:0] t_sine_rom [SINE_TABLE_DEPTH];

    // octave 0 pitch of one semitone, q4.24
    function automatic logic [FREQ_W-1:0] octave0_q24(input logic [SEMI_W-1:0] semi);
        logic [FREQ_W-1:0] f;
        unique case (semi)
            4'd0:    f = 28'd137167144;
            4'd1:    f = 28'd145323527;
            4'd2:    f = 28'd153964914;
            4'd3:    f = 28'd163120144;
            4'd4:    f = 28'd172819772;
            4'd5:    f = 28'd183096171;
            4'd6:    f = 28'd193983636;
            4'd7:    f = 28'd205518503;
            4'd8:    f = 28'd217739269;
            4'd9:    f = 28'd230686720;
            4'd10:   f = 28'd244404066;
            4'd11:   f = 28'd258937088;
            default: f = '0;
        endcase
        return f;
    endfunction

    // quarter-wave sine by a q30 taylor series, r in 0..depth
    function automatic logic [63:0] quarter_sine(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (HALF_PI_Q30 * r) / 64'(SINE_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        return (s * SAMPLE_FULL + (Q30_ONE >> 1)) >> 30;
    endfunction

    // full-wave table, worked out at elaboration
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        logic [63:0] d;
        logic [63:0] u;
        logic [63:0] r;
        logic [63:0] v;
        logic        neg;
        d = 64'(SINE_TABLE_DEPTH);
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            u = 64'(i) << 2;
            if (u <= d) begin
                r   = u;
                neg = 1'b0;
            end else if (u <= 2 * d) begin
                r   = 2 * d - u;
                neg = 1'b0;
            end else if (u <= 3 * d) begin
                r   = u - 2 * d;
                neg = 1'b1;
            end else begin
                r   = 4 * d - u;
                neg = 1'b1;
            end
            v = quarter_sine(r);
            rom[i] = neg ? -SAMPLE_BITS'(v) : SAMPLE_BITS'(v);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sve_ctrl.sv
// ----------------------------------------------------------------------------
// sve_ctrl
// sequencer: accepts words, steps the divider and the sample pipeline,
// owns the output valid flag
// ----------------------------------------------------------------------------
`default_nettype none
`include "sine_voice_with_envelope_core_defines.svh"

module sve_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [sve_pkg::CMD_W-1:0] i_cmd,
    output logic                     o_in_ready,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output sve_pkg::t_dp_cmd         o_dp_cmd
);
    import sve_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        o_dp_cmd    = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (t_op'(i_cmd))
                        OP_TICK: begin
                            o_dp_cmd.tick = 1'b1;
                            n_state       = S_MUL_LEVEL;
                        end
                        OP_NOTE_ON: begin
                            o_dp_cmd.note_on = 1'b1;
                            n_count          = CNT_W'(PHASE_BITS);
                            n_state          = S_DIV;
                        end
                        OP_NOTE_OFF: begin
                            o_dp_cmd.note_off = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                o_dp_cmd.div_step = 1'b1;
                if (r_count == '0) begin
                    o_dp_cmd.div_last = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_MUL_LEVEL: begin
                o_dp_cmd.mul_level = 1'b1;
                n_state            = S_MUL_ENV;
            end
            S_MUL_ENV: begin
                o_dp_cmd.mul_env = 1'b1;
                n_state          = S_SCALE;
            end
            S_SCALE: begin
                o_dp_cmd.scale = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                // load only when the output register is free this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_dp_cmd.load_out = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // checks
    `SVE_ASSERT_NEXT(a_div_ends, (r_state == S_DIV) && (r_count == '0), r_state == S_IDLE)
    `SVE_ASSERT_NEXT(a_out_held, (r_state == S_OUT) && r_out_valid && !i_out_ready, (r_state == S_OUT) && r_out_valid)
    `SVE_ASSERT_NEXT(a_note_on_div, o_in_ready && i_in_valid && (i_cmd == OP_NOTE_ON), (r_state == S_DIV) && (r_count == CNT_W'(PHASE_BITS)))

endmodule

`default_nettype wire

FILE: hw/rtl/sve_datapath.sv
// ----------------------------------------------------------------------------
// sve_datapath
// voice state, sine rom, phase step divider and the sample scaling pipe
// ----------------------------------------------------------------------------
`default_nettype none
`include "sine_voice_with_envelope_core_defines.svh"

module sve_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sve_pkg::t_dp_cmd                     i_dp_cmd,
    input  logic                                 i_cfg_we,
    input  logic [sve_pkg::RATE_W-1:0]           i_cfg_wdata,
    input  logic [sve_pkg::NOTE_W-1:0]           i_note,
    input  logic [sve_pkg::VEL_W-1:0]            i_velocity,
    input  logic                                 i_allow_tail,
    output logic signed [sve_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                 o_active
);
    import sve_pkg::*;

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    // voice state
    logic [RATE_W-1:0]     r_sample_rate, n_sample_rate;
    logic [PHASE_BITS-1:0] r_phase_acc, n_phase_acc;
    logic [PHASE_BITS-1:0] r_phase_step, n_phase_step;
    logic [VEL_W-1:0]      r_note_level, n_note_level;
    logic [ENV_W-1:0]      r_release_gain, n_release_gain;
    logic [ENV_W-1:0]      r_attack_ramp, n_attack_ramp;

    // divider
    logic [DIV_W-1:0]      r_rem, n_rem;
    logic [DIV_W-1:0]      r_dvs, n_dvs;
    logic [PHASE_BITS-1:0] r_quot, n_quot;

    // sample pipe
    logic signed [SAMPLE_BITS-1:0] r_sine;
    logic [VEL_W-1:0]              r_level_cap;
    logic [ENV_W-1:0]              r_env_cap;
    logic                          r_active_cap;
    logic                          r_neg;
    logic [P1_W-1:0]               r_p1;
    logic [P2_W-1:0]               r_p2;
    logic [SAMPLE_BITS-1:0]        r_q;
    logic [SAMPLE_BITS-1:0]        r_sample_out;
    logic                          r_active_out;

    // combinational helpers
    logic                   running;
    logic [ENV_W-1:0]       env_sel;
    logic [ENV_W-1:0]       decay_in;
    logic [2*ENV_W:0]       decay_prod;
    logic [ENV_W-1:0]       decay_out;
    logic                   release_end;
    logic                   tick_active;
    logic [ROM_ADDR_W-1:0]  rom_addr;
    logic [DIV12_W-1:0]     oct_prod;
    logic [OCT_W-1:0]       oct;
    logic [NOTE_W-1:0]      semi_full;
    logic [FREQ_W-1:0]      freq;
    logic [WIDE_W-1:0]      freq_wide;
    logic [NUM_W-1:0]       num;
    logic                   div_ge;
    logic [PHASE_BITS:0]    quot_next;
    logic [PHASE_BITS-1:0]  step_final;
    logic [MAG_W-1:0]       sine_mag;
    logic [P2_W:0]          y_sum;
    logic [Y_W-1:0]         y_val;
    logic [SCALE_W-1:0]     scale_prod;

    // envelope select and one decay step
    assign running     = r_phase_step != '0;
    assign env_sel     = (r_release_gain != '0) ? r_release_gain :
                         (r_attack_ramp != '0)  ? ENV_ONE - r_attack_ramp : ENV_ONE;
    assign decay_in    = (r_release_gain != '0) ? r_release_gain : r_attack_ramp;
    assign decay_prod  = (2*ENV_W+1)'(decay_in) * (2*ENV_W+1)'(DECAY_Q16)
                       + (2*ENV_W+1)'(DECAY_ROUND);
    assign decay_out   = decay_prod[DECAY_FRAC +: ENV_W];
    assign release_end = (r_release_gain != '0) && (decay_out <= ENV_FLOOR);
    assign tick_active = running && !release_end;
    assign rom_addr    = r_phase_acc[PHASE_BITS-1 -: ROM_ADDR_W];

    // note to octave and semitone, then the shifted pitch numerator
    assign oct_prod  = DIV12_W'(i_note) * DIV12_W'(DIV12_MUL);
    assign oct       = oct_prod[DIV12_SHIFT +: OCT_W];
    assign semi_full = i_note - NOTE_W'(NOTE_W'(oct) * NOTE_W'(NOTES_PER_OCT));
    assign freq      = octave0_q24(semi_full[SEMI_W-1:0]);
    assign freq_wide = WIDE_W'({freq, {PHASE_BITS{1'b0}}}) << oct;
    assign num       = freq_wide[FREQ_FRAC +: NUM_W];

    // restoring divide step; top quotient bit flags overflow
    assign div_ge     = r_rem >= r_dvs;
    assign quot_next  = {r_quot, div_ge};
    assign step_final = quot_next[PHASE_BITS] ? {PHASE_BITS{1'b1}} :
                        (quot_next[PHASE_BITS-1:0] == '0) ? PHASE_BITS'(1) :
                        quot_next[PHASE_BITS-1:0];

    // scaling: round, drop the q15 part, then divide by 127 by reciprocal
    assign sine_mag   = r_sine[SAMPLE_BITS-1] ? MAG_W'(-r_sine) : MAG_W'(r_sine);
    assign y_sum      = (P2_W+1)'(r_p2) + (P2_W+1)'(LEVEL_HALF);
    assign y_val      = y_sum[P2_W:ENV_FRAC];
    assign scale_prod = SCALE_W'(y_val) * SCALE_W'(LEVEL_RECIP);

    // next voice and divider state
    always_comb begin
        n_sample_rate  = r_sample_rate;
        n_phase_acc    = r_phase_acc;
        n_phase_step   = r_phase_step;
        n_note_level   = r_note_level;
        n_release_gain = r_release_gain;
        n_attack_ramp  = r_attack_ramp;
        n_rem          = r_rem;
        n_dvs          = r_dvs;
        n_quot         = r_quot;

        if (i_cfg_we) begin
            n_sample_rate = i_cfg_wdata;
        end

        // tick advances only a sounding voice
        if (i_dp_cmd.tick && running) begin
            n_phase_acc = r_phase_acc + r_phase_step;
            if (r_release_gain != '0) begin
                if (release_end) begin
                    n_release_gain = '0;
                    n_phase_step   = '0;
                end else begin
                    n_release_gain = decay_out;
                end
            end else if (r_attack_ramp != '0) begin
                n_attack_ramp = (decay_out <= ENV_FLOOR) ? '0 : decay_out;
            end
        end

        // note on: restart and load the divider
        if (i_dp_cmd.note_on) begin
            n_phase_acc    = '0;
            n_note_level   = i_velocity;
            n_release_gain = '0;
            if (r_attack_ramp == '0) begin
                n_attack_ramp = ENV_ONE;
            end
            n_rem  = DIV_W'(num);
            n_dvs  = {r_sample_rate, {PHASE_BITS{1'b0}}};
            n_quot = '0;
        end

        // note off: end attack, release or stop
        if (i_dp_cmd.note_off) begin
            n_attack_ramp = '0;
            if (i_allow_tail) begin
                if (r_release_gain == '0) begin
                    n_release_gain = ENV_ONE;
                end
            end else begin
                n_phase_step = '0;
            end
        end

        if (i_dp_cmd.div_step) begin
            n_rem  = div_ge ? r_rem - r_dvs : r_rem;
            n_dvs  = r_dvs >> 1;
            n_quot = quot_next[PHASE_BITS-1:0];
            if (i_dp_cmd.div_last) begin
                n_phase_step = step_final;
            end
        end
    end

    // voice state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate  <= RATE_RESET;
            r_phase_acc    <= '0;
            r_phase_step   <= '0;
            r_note_level   <= '0;
            r_release_gain <= '0;
            r_attack_ramp  <= '0;
        end else begin
            r_sample_rate  <= n_sample_rate;
            r_phase_acc    <= n_phase_acc;
            r_phase_step   <= n_phase_step;
            r_note_level   <= n_note_level;
            r_release_gain <= n_release_gain;
            r_attack_ramp  <= n_attack_ramp;
        end
    end

    // divider registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

    // rom read and sample pipe
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.tick) begin
            r_sine       <= SINE_ROM[rom_addr];
            r_level_cap  <= running ? r_note_level : '0;
            r_env_cap    <= env_sel;
            r_active_cap <= tick_active;
        end
        if (i_dp_cmd.mul_level) begin
            r_p1  <= P1_W'(sine_mag) * P1_W'(r_level_cap);
            r_neg <= r_sine[SAMPLE_BITS-1];
        end
        if (i_dp_cmd.mul_env) begin
            r_p2 <= P2_W'(r_p1) * P2_W'(r_env_cap);
        end
        if (i_dp_cmd.scale) begin
            r_q <= scale_prod[LEVEL_SHIFT +: SAMPLE_BITS];
        end
        if (i_dp_cmd.load_out) begin
            r_sample_out <= r_neg ? -r_q : r_q;
            r_active_out <= r_active_cap;
        end
    end

    assign o_sample_out = r_sample_out;
    assign o_active     = r_active_out;

    // checks
    `SVE_ASSERT_ALWAYS(a_env_bounded, (r_release_gain <= ENV_ONE) && (r_attack_ramp <= ENV_ONE))
    `SVE_ASSERT_NEXT(a_step_set, i_dp_cmd.div_last, r_phase_step != '0)
    `SVE_ASSERT_NEXT(a_note_on_restart, i_dp_cmd.note_on, (r_phase_acc == '0) && (r_release_gain == '0) && (r_attack_ramp != '0))

endmodule

`default_nettype wire

FILE: hw/rtl/sine_voice_with_envelope_core.sv
// ----------------------------------------------------------------------------
// sine_voice_with_envelope_core
// one synth voice: phase accumulator sine with velocity level and
// exponential attack and release
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+---------------------------------
//  in       | input     | i_in_valid / o_in_ready    | cmd, note, velocity, allow_tail
//  out      | output    | o_out_valid / i_out_ready  | sample_out, active
//  cfg      | input     | i_cfg_we                   | sample_rate_hz
//
//  note on: the serial phase step divider works out a 33-bit quotient one bit at a time
//  tick: rom read, three multiply stages and the output load, plus any
//  wait for the output register to free up; note off: taken without leaving idle
//  a finished word waits in the output register while the next word is taken
//  synchronous active-low reset clears the voice, rate back to 48000
// ----------------------------------------------------------------------------
`default_nettype none

module sine_voice_with_envelope_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sve_pkg::RATE_W-1:0]           i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [sve_pkg::CMD_W-1:0]            i_cmd,
    input  logic [sve_pkg::NOTE_W-1:0]           i_note,
    input  logic [sve_pkg::VEL_W-1:0]            i_velocity,
    input  logic                                 i_allow_tail,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [sve_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                 o_active
);
    import sve_pkg::*;

    t_dp_cmd dp_cmd;

    // sequencer
    sve_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_dp_cmd    (dp_cmd)
    );

    // datapath
    sve_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp_cmd     (dp_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_note       (i_note),
        .i_velocity   (i_velocity),
        .i_allow_tail (i_allow_tail),
        .o_sample_out (o_sample_out),
        .o_active     (o_active)
    );

endmodule

`default_nettype wire
